@@ hdl/afjf_pkg.sv @@
// Package of the audio frame jitter FIFO: codes, default sizes and shared types.
// No dependencies; compile first.
package afjf_pkg;

    // Default sizes, used as parameter defaults at the top level.
    localparam int SLOTS_DEF       = 16;
    localparam int FRAME_BYTES_DEF = 64;

    // Reset value of the jitter depth register.
    localparam logic [3:0] DEPTH_RST = 4'd3;

    // Packed metadata: sequence, timestamp and length.
    localparam int SEQ_W  = 16;
    localparam int TS_W   = 32;
    localparam int LEN_W  = 7;
    localparam int META_W = SEQ_W + TS_W + LEN_W;

    localparam int CNT_N = 6;

    typedef enum logic [3:0] {
        ACT_LOAD          = 4'd0,
        ACT_COMMIT_LOCAL  = 4'd1,
        ACT_COMMIT_REMOTE = 4'd2,
        ACT_READ          = 4'd3,
        ACT_PEEK          = 4'd4,
        ACT_SKIP          = 4'd5,
        ACT_CLEAR         = 4'd6,
        ACT_RESET_STATS   = 4'd7,
        ACT_READ_STAT     = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        ST_WRITTEN   = 3'd0,
        ST_READ      = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_OVERRUN   = 3'd3,
        ST_UNDERRUN  = 3'd4,
        ST_MISSED    = 3'd5,
        ST_MAX_FILL  = 3'd6,
        ST_LAST_SEQ  = 3'd7
    } t_stat;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [LEN_W-1:0] len;
    } t_meta;

endpackage

@@ hdl/afjf_in_if.sv @@
// Input channel of the audio frame jitter FIFO: valid/ready and the command word.
// No dependencies.
interface afjf_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [2:0]  word_index;
    logic [63:0] data_word;
    logic [6:0]  frame_length;
    logic [31:0] timestamp_in;
    logic [15:0] sequence_in;
    logic [31:0] now_ms;
    logic [2:0]  stat_index;

    modport source (
        output valid, action, word_index, data_word, frame_length,
               timestamp_in, sequence_in, now_ms, stat_index,
        input  ready
    );
    modport sink (
        input  valid, action, word_index, data_word, frame_length,
               timestamp_in, sequence_in, now_ms, stat_index,
        output ready
    );
endinterface

@@ hdl/afjf_out_if.sv @@
// Result channel of the audio frame jitter FIFO: valid/ready and the result word.
// No dependencies.
interface afjf_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        last;
    logic [63:0] data_out;
    logic [15:0] sequence_out;
    logic [31:0] timestamp_out;
    logic [6:0]  length_out;
    logic [3:0]  frame_count;
    logic [6:0]  fill_percent;
    logic        jitter_ready;
    logic [31:0] stat_value;

    modport source (
        output valid, accepted, last, data_out, sequence_out, timestamp_out,
               length_out, frame_count, fill_percent, jitter_ready, stat_value,
        input  ready
    );
    modport sink (
        input  valid, accepted, last, data_out, sequence_out, timestamp_out,
               length_out, frame_count, fill_percent, jitter_ready, stat_value,
        output ready
    );
endinterface

@@ hdl/afjf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies. The read data holds while the read enable is low.
module afjf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/audio_frame_jitter_fifo_unit.sv @@
// Audio frame jitter FIFO: a ring of SLOTS audio frames with metadata and statistics.
// Depends on afjf_pkg, afjf_in_if, afjf_out_if and afjf_ram.
// Results leave through the output register; read and peek first pass the RAM registers.
// One word a cycle is taken while no result is held and no frame streams. A frame streams
// a word a cycle while the sink takes it. Reset (synchronous, active low) clears pointers,
// sequences and counters; the RAMs keep data.
module audio_frame_jitter_fifo_unit #(
    parameter int SLOTS       = afjf_pkg::SLOTS_DEF,
    parameter int FRAME_BYTES = afjf_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    afjf_in_if.sink     i_in,
    afjf_out_if.source  o_out
);

    import afjf_pkg::*;

    // Frame geometry. The payload RAM holds WORDS consecutive words for each slot.
    localparam int WORDS     = FRAME_BYTES / 8;
    localparam int PTR_W     = $clog2(SLOTS);
    localparam int PAY_DEPTH = SLOTS * WORDS;
    localparam int PAW       = $clog2(PAY_DEPTH);
    localparam int KW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int HALF      = SLOTS / 2;

    // Fill percent is count*100/SLOTS. The division by SLOTS is done as a multiplication
    // by a rounded-up reciprocal; with count*100 below 2**15 and the shift taken as
    // 15 + PTR_W bits, the truncated quotient is exact for every count.
    localparam int          PCT_SH  = 15 + PTR_W;
    localparam longint      RECIP   = ((64'd1 << PCT_SH) + SLOTS - 1) / SLOTS;
    localparam int          PROD_W  = PTR_W + 24;
    localparam longint      PCT_MUL = RECIP * 100;

    // Increment a ring pointer modulo SLOTS.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (32'(p) == SLOTS - 1) ? '0 : p + 1'b1;
    endfunction

    // Frames held between a read and a write pointer.
    function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] wp,
                                                    input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] diff;
        if (wp >= rp) begin
            diff = {1'b0, wp} - {1'b0, rp};
        end else begin
            diff = {1'b0, wp} + (PTR_W+1)'(SLOTS) - {1'b0, rp};
        end
        ring_count = diff[PTR_W-1:0];
    endfunction

    // Control and status registers.
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [PTR_W-1:0]   r_slot, n_slot;
    logic [KW-1:0]      r_k, n_k;
    logic [15:0]        r_next_seq, n_next_seq;
    logic [15:0]        r_last_seq, n_last_seq;
    logic [31:0]        r_cnt [CNT_N];
    logic [31:0]        n_cnt [CNT_N];
    logic [PTR_W-1:0]   r_max_fill, n_max_fill;
    logic [3:0]         r_depth;

    // Output register: one result word waits here for the sink.
    logic               r_o_valid, n_o_valid;
    logic               r_o_accepted, n_o_accepted;
    logic               r_o_last, n_o_last;
    logic [63:0]        r_o_data, n_o_data;
    t_meta              r_o_meta, n_o_meta;
    logic [31:0]        r_o_stat, n_o_stat;
    logic [3:0]         r_o_count;
    logic [6:0]         r_o_pct;
    logic               r_o_jr;
    logic               load_out;

    // RAM ports.
    logic               pay_we, pay_re;
    logic [PAW-1:0]     pay_waddr, pay_raddr;
    logic [63:0]        pay_rdata;
    logic               meta_we, meta_re;
    t_meta              meta_wdata, meta_rdata;

    // Handshake and derived status.
    logic               out_free, acc_in, full, empty;
    logic [PTR_W-1:0]   cur_count, next_count, fill;
    logic [6:0]         flen;
    logic [15:0]        exp_seq, seq_gap;
    logic [PROD_W-1:0]  pct_prod;

    assign out_free    = !r_o_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign acc_in      = i_in.valid && i_in.ready;
    assign full        = (ptr_inc(r_wp) == r_rp);
    assign empty       = (r_wp == r_rp);
    assign cur_count   = ring_count(r_wp, r_rp);
    assign fill        = cur_count + 1'b1;
    assign flen        = (32'(i_in.frame_length) > FRAME_BYTES) ?
                         7'(FRAME_BYTES) : i_in.frame_length;
    assign exp_seq     = r_last_seq + 16'd1;
    assign seq_gap     = i_in.sequence_in - exp_seq;

    // Count-dependent result fields are taken from the pointers after the operation.
    assign next_count  = ring_count(n_wp, n_rp);
    assign pct_prod    = PROD_W'(next_count) * PROD_W'(PCT_MUL);

    afjf_ram #(
        .WIDTH (64),
        .DEPTH (PAY_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (i_in.data_word),
        .i_re    (pay_re),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    afjf_ram #(
        .WIDTH (META_W),
        .DEPTH (SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_wp),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (r_rp),
        .o_rdata (meta_rdata)
    );

    // Next state, RAM control and the next result word.
    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_slot       = r_slot;
        n_k          = r_k;
        n_next_seq   = r_next_seq;
        n_last_seq   = r_last_seq;
        n_cnt        = r_cnt;
        n_max_fill   = r_max_fill;
        n_o_valid    = r_o_valid && !o_out.ready;
        n_o_accepted = r_o_accepted;
        n_o_last     = r_o_last;
        n_o_data     = r_o_data;
        n_o_meta     = r_o_meta;
        n_o_stat     = r_o_stat;
        load_out     = 1'b0;
        pay_we       = 1'b0;
        pay_waddr    = PAW'(r_wp) * PAW'(WORDS) + PAW'(i_in.word_index);
        pay_re       = 1'b0;
        pay_raddr    = PAW'(r_slot) * PAW'(WORDS) + PAW'(r_k) + PAW'(1);
        meta_we      = 1'b0;
        meta_wdata   = '{seq: i_in.sequence_in, ts: i_in.timestamp_in, len: flen};
        meta_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    // Single-result actions fill these; read and peek override them.
                    load_out     = 1'b1;
                    n_o_valid    = 1'b1;
                    n_o_accepted = 1'b0;
                    n_o_last     = 1'b1;
                    n_o_data     = '0;
                    n_o_meta     = '0;
                    n_o_stat     = '0;
                    case (i_in.action)
                        ACT_LOAD: begin
                            if (32'(i_in.word_index) < WORDS) begin
                                pay_we       = 1'b1;
                                n_o_accepted = 1'b1;
                            end
                        end
                        ACT_COMMIT_LOCAL: begin
                            if (full) begin
                                n_cnt[ST_OVERRUN] = r_cnt[ST_OVERRUN] + 32'd1;
                                n_cnt[ST_DROPPED] = r_cnt[ST_DROPPED] + 32'd1;
                            end else begin
                                meta_we    = 1'b1;
                                meta_wdata = '{seq: r_next_seq,
                                               ts: (i_in.timestamp_in != '0) ?
                                                   i_in.timestamp_in : i_in.now_ms,
                                               len: flen};
                                n_cnt[ST_WRITTEN] = r_cnt[ST_WRITTEN] + 32'd1;
                                n_next_seq = r_next_seq + 16'd1;
                                if (fill > r_max_fill) begin
                                    n_max_fill = fill;
                                end
                                n_wp         = ptr_inc(r_wp);
                                n_o_accepted = 1'b1;
                            end
                        end
                        ACT_COMMIT_REMOTE: begin
                            // The gap is counted before this frame is stamped, and only
                            // once anything has been written since the last stats reset.
                            if (i_in.sequence_in != exp_seq && r_cnt[ST_WRITTEN] != '0) begin
                                n_cnt[ST_MISSED] = r_cnt[ST_MISSED] + 32'(seq_gap);
                            end
                            n_last_seq = i_in.sequence_in;
                            if (full) begin
                                n_cnt[ST_OVERRUN] = r_cnt[ST_OVERRUN] + 32'd1;
                                n_cnt[ST_DROPPED] = r_cnt[ST_DROPPED] + 32'd1;
                            end else begin
                                meta_we           = 1'b1;
                                n_cnt[ST_WRITTEN] = r_cnt[ST_WRITTEN] + 32'd1;
                                n_wp              = ptr_inc(r_wp);
                                n_o_accepted      = 1'b1;
                            end
                        end
                        ACT_READ, ACT_PEEK: begin
                            if (empty) begin
                                if (i_in.action == ACT_READ) begin
                                    n_cnt[ST_UNDERRUN] = r_cnt[ST_UNDERRUN] + 32'd1;
                                end
                            end else begin
                                if (i_in.action == ACT_READ) begin
                                    n_cnt[ST_READ] = r_cnt[ST_READ] + 32'd1;
                                    n_rp           = ptr_inc(r_rp);
                                end
                                // Fetch the first word and the metadata of the head frame.
                                load_out  = 1'b0;
                                n_o_valid = r_o_valid && !o_out.ready;
                                meta_re   = 1'b1;
                                pay_re    = 1'b1;
                                pay_raddr = PAW'(r_rp) * PAW'(WORDS);
                                n_slot    = r_rp;
                                n_k       = '0;
                                n_state   = S_READ;
                            end
                        end
                        ACT_SKIP: begin
                            if (!empty) begin
                                n_rp         = ptr_inc(r_rp);
                                n_o_accepted = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_wp         = '0;
                            n_rp         = '0;
                            n_o_accepted = 1'b1;
                        end
                        ACT_RESET_STATS: begin
                            for (int i = 0; i < CNT_N; i++) begin
                                n_cnt[i] = '0;
                            end
                            n_max_fill   = '0;
                            n_last_seq   = '0;
                            n_o_accepted = 1'b1;
                        end
                        ACT_READ_STAT: begin
                            n_o_accepted = 1'b1;
                            case (i_in.stat_index) inside
                                [ST_WRITTEN:ST_MISSED]: n_o_stat = r_cnt[i_in.stat_index];
                                ST_MAX_FILL:            n_o_stat = 32'(r_max_fill);
                                default:                n_o_stat = 32'(r_last_seq);
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // The RAM data for word r_k is held until the output register is free.
                if (out_free) begin
                    load_out     = 1'b1;
                    n_o_valid    = 1'b1;
                    n_o_accepted = 1'b1;
                    n_o_last     = (32'(r_k) == WORDS - 1);
                    n_o_data     = pay_rdata;
                    n_o_meta     = meta_rdata;
                    n_o_stat     = '0;
                    if (32'(r_k) == WORDS - 1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k    = r_k + 1'b1;
                        pay_re = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_next_seq <= '0;
            r_last_seq <= '0;
            r_max_fill <= '0;
            r_o_valid  <= 1'b0;
            r_depth    <= DEPTH_RST;
            for (int i = 0; i < CNT_N; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_next_seq <= n_next_seq;
            r_last_seq <= n_last_seq;
            r_max_fill <= n_max_fill;
            r_o_valid  <= n_o_valid;
            r_cnt      <= n_cnt;
            // A depth beyond half the ring is held at half the ring.
            if (i_cfg_we) begin
                r_depth <= (32'(i_cfg_wdata) > HALF) ? 4'(HALF) : i_cfg_wdata;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_k          <= n_k;
        r_o_accepted <= n_o_accepted;
        r_o_last     <= n_o_last;
        r_o_data     <= n_o_data;
        r_o_meta     <= n_o_meta;
        r_o_stat     <= n_o_stat;
        if (load_out) begin
            r_o_count <= 4'(next_count);
            r_o_pct   <= 7'(pct_prod >> PCT_SH);
            r_o_jr    <= (32'(next_count) >= 32'(r_depth));
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.accepted      = r_o_accepted;
    assign o_out.last          = r_o_last;
    assign o_out.data_out      = r_o_data;
    assign o_out.sequence_out  = r_o_meta.seq;
    assign o_out.timestamp_out = r_o_meta.ts;
    assign o_out.length_out    = r_o_meta.len;
    assign o_out.frame_count   = r_o_count;
    assign o_out.fill_percent  = r_o_pct;
    assign o_out.jitter_ready  = r_o_jr;
    assign o_out.stat_value    = r_o_stat;

endmodule

@@ tb/sv/tb_audio_frame_jitter_fifo_unit.sv @@
// Self-checking testbench of the audio frame jitter FIFO: a predictor-backed scoreboard and
// the stimulus that drives command words in and collects result words under random stalls.
// Depends on afjf_pkg, afjf_in_if, afjf_out_if and audio_frame_jitter_fifo_unit.
module tb_audio_frame_jitter_fifo_unit;

    import afjf_pkg::*;

    localparam int NSLOT       = SLOTS_DEF;
    localparam int FRAME_BYTES = FRAME_BYTES_DEF;
    localparam int FRAME_WORDS = FRAME_BYTES_DEF / 8;

    // Action codes that the block does not decode.
    localparam logic [3:0] ACT_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;

    // Percentage of cycles in which either side idles, and how long the receiver
    // holds off to make the ring back up into the input channel.
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 300;
    // A read streams a whole frame, so allow that much time to settle after the
    // last expected word before touching the register or ending.
    localparam int SETTLE       = FRAME_WORDS + 4;

    typedef struct packed {
        logic [3:0]  action;
        logic [2:0]  word_index;
        logic [63:0] data_word;
        logic [6:0]  frame_length;
        logic [31:0] timestamp_in;
        logic [15:0] sequence_in;
        logic [31:0] now_ms;
        logic [2:0]  stat_index;
    } t_fifo_cmd;

    typedef struct packed {
        logic        accepted;
        logic        last;
        logic [63:0] data;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [6:0]  len;
        logic [3:0]  count;
        logic [6:0]  fill;
        logic        jready;
        logic [31:0] stat;
    } t_fifo_result;

    // Shadow of the ring, its metadata and its statistics, plus the queue of result words
    // that the block still owes.
    class t_jitter_fifo_scoreboard;
        logic [63:0]            frame_words [NSLOT][FRAME_WORDS];
        logic [FRAME_WORDS-1:0] loaded      [NSLOT];
        logic [15:0]            slot_seq    [NSLOT];
        logic [31:0]            slot_stamp  [NSLOT];
        logic [6:0]             slot_len    [NSLOT];
        int unsigned            wr_slot;
        int unsigned            rd_slot;
        logic [15:0]            local_seq;
        logic [15:0]            remote_seq;
        logic [31:0]            tally       [CNT_N];
        logic [3:0]             peak_fill;
        logic [3:0]             depth;
        t_fifo_result           pending[$];
        int unsigned            checked;
        int unsigned            errors;

        function new();
            wr_slot    = 0;
            rd_slot    = 0;
            local_seq  = '0;
            remote_seq = '0;
            peak_fill  = '0;
            depth      = DEPTH_RST;
            checked    = 0;
            errors     = 0;
            foreach (tally[i]) tally[i] = '0;
            foreach (loaded[i]) loaded[i] = '0;
        endfunction

        function void write_depth(logic [3:0] v);
            depth = (v > NSLOT / 2) ? 4'(NSLOT / 2) : v;
        endfunction

        function int unsigned held();
            return (wr_slot + NSLOT - rd_slot) % NSLOT;
        endfunction

        function bit ring_full();
            return ((wr_slot + 1) % NSLOT) == rd_slot;
        endfunction

        // A commit into a slot whose payload was never fully loaded would later expose
        // undefined RAM contents, so the stimulus only commits when this holds.
        function bit commit_safe();
            return ring_full() || (&loaded[wr_slot]);
        endfunction

        function t_fifo_result status(logic ok);
            t_fifo_result r;
            int unsigned  n;
            n        = held();
            r        = '0;
            r.accepted = ok;
            r.count  = 4'(n);
            r.fill   = 7'(n * 100 / NSLOT);
            r.jready = (n >= depth);
            return r;
        endfunction

        function void stamp_slot(logic [15:0] seq, logic [31:0] stamp, logic [6:0] len);
            slot_seq[wr_slot]   = seq;
            slot_stamp[wr_slot] = stamp;
            slot_len[wr_slot]   = len;
            tally[ST_WRITTEN]++;
            wr_slot = (wr_slot + 1) % NSLOT;
        endfunction

        function void note_input(t_fifo_cmd c);
            logic         ok;
            logic [31:0]  stat;
            logic [6:0]   len;
            logic [15:0]  want_seq;
            int unsigned  slot;
            int unsigned  fill;
            t_fifo_result r;
            ok   = 1'b0;
            stat = '0;
            len  = (c.frame_length > FRAME_BYTES) ? 7'(FRAME_BYTES) : c.frame_length;
            case (c.action)
                ACT_LOAD: begin
                    if (c.word_index < FRAME_WORDS) begin
                        frame_words[wr_slot][c.word_index] = c.data_word;
                        loaded[wr_slot][c.word_index]      = 1'b1;
                        ok = 1'b1;
                    end
                end
                ACT_COMMIT_LOCAL: begin
                    if (ring_full()) begin
                        tally[ST_OVERRUN]++;
                        tally[ST_DROPPED]++;
                    end else begin
                        fill = held() + 1;
                        stamp_slot(local_seq,
                                   (c.timestamp_in != 0) ? c.timestamp_in : c.now_ms, len);
                        local_seq++;
                        if (fill > peak_fill) peak_fill = 4'(fill);
                        ok = 1'b1;
                    end
                end
                ACT_COMMIT_REMOTE: begin
                    want_seq = remote_seq + 16'd1;
                    if (c.sequence_in != want_seq && tally[ST_WRITTEN] != 0) begin
                        tally[ST_MISSED] += 32'(16'(c.sequence_in - want_seq));
                    end
                    remote_seq = c.sequence_in;
                    if (ring_full()) begin
                        tally[ST_OVERRUN]++;
                        tally[ST_DROPPED]++;
                    end else begin
                        stamp_slot(c.sequence_in, c.timestamp_in, len);
                        ok = 1'b1;
                    end
                end
                ACT_READ, ACT_PEEK: begin
                    if (wr_slot == rd_slot) begin
                        if (c.action == ACT_READ) tally[ST_UNDERRUN]++;
                    end else begin
                        slot = rd_slot;
                        if (c.action == ACT_READ) begin
                            tally[ST_READ]++;
                            rd_slot = (rd_slot + 1) % NSLOT;
                        end
                        for (int k = 0; k < FRAME_WORDS; k++) begin
                            r       = status(1'b1);
                            r.last  = (k == FRAME_WORDS - 1);
                            r.data  = frame_words[slot][k];
                            r.seq   = slot_seq[slot];
                            r.stamp = slot_stamp[slot];
                            r.len   = slot_len[slot];
                            pending.push_back(r);
                        end
                        return;
                    end
                end
                ACT_SKIP: begin
                    if (wr_slot != rd_slot) begin
                        rd_slot = (rd_slot + 1) % NSLOT;
                        ok = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    wr_slot = 0;
                    rd_slot = 0;
                    ok = 1'b1;
                end
                ACT_RESET_STATS: begin
                    foreach (tally[i]) tally[i] = '0;
                    peak_fill  = '0;
                    remote_seq = '0;
                    ok = 1'b1;
                end
                ACT_READ_STAT: begin
                    if (c.stat_index < ST_MAX_FILL) stat = tally[c.stat_index];
                    else if (c.stat_index == ST_MAX_FILL) stat = 32'(peak_fill);
                    else stat = 32'(remote_seq);
                    ok = 1'b1;
                end
                default: ;
            endcase
            r      = status(ok);
            r.last = 1'b1;
            r.stat = stat;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t: result word %0d: %s", $time, checked, msg);
            errors++;
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
        endtask

        task check_result(t_fifo_result got);
            t_fifo_result want;
            checked++;
            if (pending.size() == 0) begin
                report("result word arrived with nothing outstanding");
                return;
            end
            want = pending.pop_front();
            compare("accepted",      got.accepted, want.accepted);
            compare("last",          got.last,     want.last);
            compare("data_out",      got.data,     want.data);
            compare("sequence_out",  got.seq,      want.seq);
            compare("timestamp_out", got.stamp,    want.stamp);
            compare("length_out",    got.len,      want.len);
            compare("frame_count",   got.count,    want.count);
            compare("fill_percent",  got.fill,     want.fill);
            compare("jitter_ready",  got.jready,   want.jready);
            compare("stat_value",    got.stat,     want.stat);
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;

    afjf_in_if  in_ch ();
    afjf_out_if out_ch ();

    audio_frame_jitter_fifo_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_jitter_fifo_scoreboard sb;
    t_fifo_result            seen;
    int unsigned             items_sent;
    int                      hold_left;
    bit                      calm;

    always #5 i_clk = ~i_clk;

    // The receiver decides its ready on the falling edge. A pending hold-off takes
    // priority; otherwise it stalls at random unless the current phase is calm.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every result word that crosses the handshake is checked against the oldest
    // expectation. Sampling on the rising edge sees the values the block acted on.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.accepted = out_ch.accepted;
            seen.last     = out_ch.last;
            seen.data     = out_ch.data_out;
            seen.seq      = out_ch.sequence_out;
            seen.stamp    = out_ch.timestamp_out;
            seen.len      = out_ch.length_out;
            seen.count    = out_ch.frame_count;
            seen.fill     = out_ch.fill_percent;
            seen.jready   = out_ch.jitter_ready;
            seen.stat     = out_ch.stat_value;
            sb.check_result(seen);
        end
    end

    // Every field is random so that each input bit toggles, whatever the action uses.
    function automatic t_fifo_cmd noise_cmd(logic [3:0] action);
        t_fifo_cmd c;
        c.action       = action;
        c.word_index   = 3'($urandom);
        c.data_word    = {$urandom, $urandom};
        c.frame_length = 7'($urandom);
        c.timestamp_in = $urandom;
        c.sequence_in  = 16'($urandom);
        c.now_ms       = $urandom;
        c.stat_index   = 3'($urandom);
        return c;
    endfunction

    // Local commits sometimes leave the timestamp at zero so that now_ms is taken.
    // Remote commits mostly follow on from the last sequence, with the odd gap.
    function automatic t_fifo_cmd commit_cmd(logic remote);
        t_fifo_cmd c;
        c = noise_cmd(remote ? ACT_COMMIT_REMOTE : ACT_COMMIT_LOCAL);
        if (!remote && $urandom_range(0, 3) == 0) c.timestamp_in = '0;
        if (remote && $urandom_range(0, 3) != 0) c.sequence_in = sb.remote_seq + 16'd1;
        return c;
    endfunction

    // Offers one command word. Entered on a falling edge; leaves on the falling edge
    // after the handshake with valid still high, so that back-to-back words never
    // lower and raise valid within one time step.
    task automatic offer(t_fifo_cmd c);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.action       <= c.action;
        in_ch.word_index   <= c.word_index;
        in_ch.data_word    <= c.data_word;
        in_ch.frame_length <= c.frame_length;
        in_ch.timestamp_in <= c.timestamp_in;
        in_ch.sequence_in  <= c.sequence_in;
        in_ch.now_ms       <= c.now_ms;
        in_ch.stat_index   <= c.stat_index;
        in_ch.valid        <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(c);
        items_sent++;
        @(negedge i_clk);
    endtask

    // A well-formed frame: every payload word of the write slot, then a commit.
    task automatic send_frame(logic remote);
        t_fifo_cmd c;
        for (int w = 0; w < FRAME_WORDS; w++) begin
            c = noise_cmd(ACT_LOAD);
            c.word_index = 3'(w);
            offer(c);
        end
        offer(commit_cmd(remote));
    endtask

    // Lowers valid and waits until every result word has come back, plus a margin.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_depth(logic [3:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_depth(v);
    endtask

    // Whole frames with random content as the largest share, mixed with reads, peeks, skips,
    // statistics reads and the occasional clear, stats reset, stray load or
    // undecoded action. Commits that would expose an unloaded slot become frames.
    task automatic random_run(int unsigned budget);
        t_fifo_cmd   c;
        int unsigned start;
        int unsigned roll;
        start = items_sent;
        while (items_sent - start < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                send_frame($urandom_range(0, 99) < 40);
            end else begin
                if (roll < 60) c = noise_cmd(ACT_READ);
                else if (roll < 68) c = noise_cmd(ACT_PEEK);
                else if (roll < 75) c = noise_cmd(ACT_SKIP);
                else if (roll < 84) c = noise_cmd(ACT_READ_STAT);
                else if (roll < 88) c = commit_cmd(roll[0]);
                else if (roll < 91) c = noise_cmd(ACT_CLEAR);
                else if (roll < 93) c = noise_cmd(ACT_RESET_STATS);
                else if (roll < 95) c = noise_cmd(4'($urandom_range(ACT_UNUSED_FIRST,
                                                                     ACT_UNUSED_LAST)));
                else c = noise_cmd(ACT_LOAD);
                if ((c.action == ACT_COMMIT_LOCAL || c.action == ACT_COMMIT_REMOTE)
                        && !sb.commit_safe()) begin
                    send_frame(c.action == ACT_COMMIT_REMOTE);
                end else begin
                    offer(c);
                end
            end
        end
    endtask

    initial begin
        t_fifo_cmd c;
        sb                 = new;
        items_sent         = 0;
        hold_left          = 0;
        calm               = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        out_ch.ready       = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = '0;
        in_ch.word_index   = '0;
        in_ch.data_word    = '0;
        in_ch.frame_length = '0;
        in_ch.timestamp_in = '0;
        in_ch.sequence_in  = '0;
        in_ch.now_ms       = '0;
        in_ch.stat_index   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, run at the reset depth. Empty-ring behaviour first: a read
        // counts an underrun, while peek and skip change nothing.
        offer(noise_cmd(ACT_READ));
        offer(noise_cmd(ACT_PEEK));
        offer(noise_cmd(ACT_SKIP));
        c = noise_cmd(ACT_READ_STAT);
        c.stat_index = ST_UNDERRUN;
        offer(c);

        // One frame with all-ones and all-zero words at its ends, committed as a
        // remote frame while nothing has been written yet, so no gap is counted.
        for (int w = 0; w < FRAME_WORDS; w++) begin
            c = noise_cmd(ACT_LOAD);
            c.word_index = 3'(w);
            if (w == 0) c.data_word = '1;
            if (w == FRAME_WORDS - 1) c.data_word = '0;
            offer(c);
        end
        c = noise_cmd(ACT_COMMIT_REMOTE);
        c.sequence_in  = '0;
        c.timestamp_in = '0;
        c.frame_length = '1;
        offer(c);
        offer(noise_cmd(ACT_PEEK));
        offer(noise_cmd(ACT_READ));

        // Clearing puts the pointers back on slot 0, whose payload is still held,
        // so commits can follow without fresh loads. The local one takes now_ms.
        offer(noise_cmd(ACT_CLEAR));
        c = noise_cmd(ACT_COMMIT_LOCAL);
        c.timestamp_in = '0;
        c.now_ms       = '1;
        c.frame_length = '0;
        offer(c);
        offer(noise_cmd(ACT_CLEAR));

        // A remote sequence of all ones after sequence zero: a gap of 0xFFFE missed frames.
        c = noise_cmd(ACT_COMMIT_REMOTE);
        c.sequence_in  = '1;
        c.timestamp_in = '1;
        c.frame_length = 7'(FRAME_BYTES);
        offer(c);
        offer(noise_cmd(ACT_SKIP));
        c = noise_cmd(ACT_READ_STAT);
        c.stat_index = ST_MISSED;
        offer(c);
        c.stat_index = ST_LAST_SEQ;
        offer(c);
        offer(noise_cmd(ACT_UNUSED_LAST));
        offer(noise_cmd(ACT_RESET_STATS));
        c = noise_cmd(ACT_READ_STAT);
        c.stat_index = ST_MAX_FILL;
        offer(c);
        c.stat_index = ST_WRITTEN;
        offer(c);
        drain();

        // Back-pressure: the receiver holds off for a long stretch while frames keep
        // coming, so the input stalls. Seventeen frames overfill the ring, which
        // gives loads into the free slot and commits that overrun.
        set_depth(4'hF);
        hold_left = HOLD_CYCLES;
        for (int f = 0; f < NSLOT + 1; f++) send_frame(f[0]);
        drain();

        // Random part in chunks, each at its own depth; the second runs without idling.
        set_depth(4'h0);
        random_run(60);
        drain();
        set_depth(4'(NSLOT / 2));
        calm = 1'b1;
        random_run(60);
        drain();
        calm = 1'b0;
        set_depth(4'($urandom));
        random_run(60);
        drain();
        set_depth(4'h1);
        random_run(60);
        drain();

        if (sb.errors == 0) begin
            $display("tb_audio_frame_jitter_fifo_unit: PASS");
        end else begin
            $display("tb_audio_frame_jitter_fifo_unit: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall at its longest.
    initial begin
        #2000000;
        $display("tb_audio_frame_jitter_fifo_unit: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/afjf_pkg.sv
hdl/afjf_in_if.sv
hdl/afjf_out_if.sv
hdl/afjf_ram.sv
hdl/audio_frame_jitter_fifo_unit.sv
tb/sv/tb_audio_frame_jitter_fifo_unit.sv
